// ===== sv/ssps_pkg.sv =====
// Shared types and constants for the starfield projection/shading block.
// No dependencies; the front, back, top level and testbench import this package.
package ssps_pkg;

    localparam int FRAME_MAX_DEF = 4096;

    // Register reset values and register indexes (paddr[2])
    localparam logic [12:0] FRAME_WIDTH_RST  = 13'd800;
    localparam logic [12:0] FRAME_HEIGHT_RST = 13'd480;
    localparam logic        REG_FRAME_WIDTH  = 1'b0;
    localparam logic        REG_FRAME_HEIGHT = 1'b1;

    // Depth thresholds (Q16)
    localparam logic [16:0] NEAR_BOUND  = 17'd655;
    localparam logic [16:0] COLOR_BOUND = 17'd22937;
    localparam logic [16:0] SIZE2_BOUND = 17'd49315;
    localparam logic [16:0] SIZE3_BOUND = 17'd16875;

    // floor(p/33) = (p * RECIP33) >> 34 for p < 2^28
    localparam logic [29:0] RECIP33     = 30'd520602097;
    // floor(x/1785) = (x * RECIP1785) >> 30 for x < 2^19
    localparam logic [19:0] RECIP1785   = 20'd601537;

    localparam logic [25:0] BRIGHT_TOP  = 26'd16711680;  // 255 * 65536
    localparam logic [17:0] MIX_DEN     = 18'd229376;

    localparam int DEN_W     = 20;   // bits of 6*depth
    localparam int MID_DEPTH = 8;    // front-to-back queue entries

    typedef struct packed {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [16:0]        z;
        logic [7:0]         tr;
        logic [7:0]         tg;
        logic [7:0]         tb;
    } t_stage;

    typedef struct packed {
        logic [16:0] nz;
        logic        recycle;
        logic [7:0]  tr;
        logic [7:0]  tg;
        logic [7:0]  tb;
    } t_star;

    typedef struct packed {
        logic [16:0] new_depth;
        logic        recycle;
        logic [11:0] screen_x;
        logic [11:0] screen_y;
        logic [1:0]  dot_size;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_result;

endpackage

// ===== sv/ssps_fifo.sv =====
// Small synchronous FIFO in flip-flops; writer guarantees no overflow.
// Depends on nothing.
module ssps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_pop;

    assign do_pop  = i_pop && !o_empty;
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// ===== sv/ssps_front.sv =====
// Front pipeline: depth update, near/off-frame classification, division operands.
// Depends on ssps_pkg; feeds the middle queue, holds its credit count.
module ssps_front import ssps_pkg::*; #(
    parameter int FRAME_MAX = FRAME_MAX_DEF,
    localparam int WB = $clog2(FRAME_MAX + 1),
    localparam int NB = WB + DEN_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic [16:0]        i_depth,
    input  logic [11:0]        i_speed,
    input  logic [7:0]         i_tint_red,
    input  logic [7:0]         i_tint_green,
    input  logic [7:0]         i_tint_blue,
    input  logic [15:0]        i_elapsed_ms,
    input  logic [WB-1:0]      i_frame_w,
    input  logic [WB-1:0]      i_frame_h,
    input  logic               i_q_pop,
    output logic               o_q_push,
    output logic [NB-1:0]      o_q_numx,
    output logic [NB-1:0]      o_q_numy,
    output t_star              o_q_star
);
    localparam int CRW = $clog2(MID_DEPTH + 1);
    localparam int SB  = WB + DEN_W + 2;

    logic [CRW-1:0] r_cred, n_cred;
    logic           accept;
    logic [4:0]     r_vld;
    t_stage         r_c [1:4];

    logic [27:0]    r_prod1;
    logic [57:0]    dec_prod;
    logic [23:0]    r_dec2;
    logic [16:0]    nz3;

    logic signed [20:0]    tx4;
    logic signed [20:0]    r_tx4;
    logic [WB+16:0]        r_hn4;
    logic signed [WB+16:0] r_dw4;
    logic                  r_near4;

    logic signed [SB-1:0] hn_s, dw_s, numy5;
    logic [NB-1:0]        hden5;
    logic [DEN_W-1:0]     six5;
    logic                 offx5, offy5;

    logic [NB-1:0] r_numx5, r_numy5;
    t_star         r_star5;

    assign accept = i_push && !o_full;
    assign o_full = (r_cred == CRW'(MID_DEPTH));

    // Credits cover items in flight here plus items sitting in the queue
    always_comb begin
        case ({accept, i_q_pop})
            2'b10:   n_cred = r_cred + 1'b1;
            2'b01:   n_cred = r_cred - 1'b1;
            default: n_cred = r_cred;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cred <= '0;
            r_vld  <= '0;
        end else begin
            r_cred <= n_cred;
            r_vld  <= {r_vld[3:0], accept};
        end
    end

    assign dec_prod = 58'(r_prod1) * 58'(RECIP33);
    assign nz3 = ({7'b0, r_c[2].z} > r_dec2) ? (r_c[2].z - r_dec2[16:0]) : '0;
    assign tx4 = $signed({3'b0, r_c[3].z, 1'b0}) + $signed({4'b0, r_c[3].z})
               + $signed({{3{r_c[3].dx[15]}}, r_c[3].dx, 2'b00});

    always_ff @(posedge i_clk) begin
        // stage 1: capture, speed * time
        r_prod1    <= 28'(i_speed) * 28'(i_elapsed_ms);
        r_c[1].dx  <= i_dir_x;
        r_c[1].dy  <= i_dir_y;
        r_c[1].z   <= i_depth;
        r_c[1].tr  <= i_tint_red;
        r_c[1].tg  <= i_tint_green;
        r_c[1].tb  <= i_tint_blue;
        // stage 2: divide by 33
        r_dec2     <= dec_prod[57:34];
        r_c[2]     <= r_c[1];
        // stage 3: saturating depth update
        r_c[3].dx  <= r_c[2].dx;
        r_c[3].dy  <= r_c[2].dy;
        r_c[3].z   <= nz3;
        r_c[3].tr  <= r_c[2].tr;
        r_c[3].tg  <= r_c[2].tg;
        r_c[3].tb  <= r_c[2].tb;
        // stage 4: projection products
        r_c[4]     <= r_c[3];
        r_tx4      <= tx4;
        r_hn4      <= (WB+17)'(i_frame_h) * (WB+17)'(r_c[3].z);
        r_dw4      <= (WB+17)'(r_c[3].dy) * (WB+17)'($signed({1'b0, i_frame_w}));
        r_near4    <= (r_c[3].z <= NEAR_BOUND);
    end

    always_comb begin
        hn_s  = $signed(SB'(r_hn4));
        dw_s  = SB'(r_dw4);
        numy5 = hn_s + (hn_s <<< 1) + (dw_s <<< 2);
        hden5 = NB'({r_hn4, 2'b00}) + NB'({r_hn4, 1'b0});
        six5  = DEN_W'({r_c[4].z, 2'b00}) + DEN_W'({r_c[4].z, 1'b0});
        offx5 = (i_frame_w == '0) || r_tx4[20] || (r_tx4[19:0] >= six5);
        offy5 = numy5[SB-1] || (numy5 >= $signed(SB'(hden5)));
    end

    always_ff @(posedge i_clk) begin
        // stage 5: classify, x numerator
        r_numx5         <= NB'(i_frame_w) * NB'(r_tx4[19:0]);
        r_numy5         <= NB'(numy5);
        r_star5.nz      <= r_c[4].z;
        r_star5.recycle <= r_near4 || offx5 || offy5;
        r_star5.tr      <= r_c[4].tr;
        r_star5.tg      <= r_c[4].tg;
        r_star5.tb      <= r_c[4].tb;
    end

    assign o_q_push = r_vld[4];
    assign o_q_numx = r_numx5;
    assign o_q_numy = r_numy5;
    assign o_q_star = r_star5;
endmodule

// ===== sv/ssps_back.sv =====
// Back pipeline: perspective divide (one quotient bit per stage), size and colour.
// Depends on ssps_pkg; pulls from the middle queue, pushes the result queue.
module ssps_back import ssps_pkg::*; #(
    parameter int FRAME_MAX = FRAME_MAX_DEF,
    parameter int OUT_DEPTH = 16,
    localparam int WB = $clog2(FRAME_MAX + 1),
    localparam int NB = WB + DEN_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    input  logic [NB-1:0] i_q_numx,
    input  logic [NB-1:0] i_q_numy,
    input  t_star         i_q_star,
    output logic          o_out_push,
    input  logic          i_out_pop,
    output t_result       o_result
);
    localparam int QB  = $clog2(FRAME_MAX);
    localparam int LAT = QB + 1;
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    logic [OCW-1:0] r_ocnt;
    logic [LAT:1]   r_vld;

    logic [16:0]      r_nz   [1:LAT];
    logic             r_rec  [1:LAT];
    logic [1:0]       r_size [1:LAT];
    logic [DEN_W-1:0] r_den  [1:QB];
    logic [DEN_W-1:0] r_rx   [1:QB];
    logic [DEN_W-1:0] r_ry   [1:QB];
    logic [QB-1:0]    r_lx   [1:LAT];
    logic [QB-1:0]    r_ly   [1:LAT];

    // colour path
    logic signed [25:0] bright;
    logic [17:0]        mix;
    logic [16:0]        nz;
    logic [7:0]         tint   [3];
    logic [23:0]        r_b1;
    logic [25:0]        r_f1   [3];
    logic               r_cb   [1:2];
    logic [7:0]         r_grey [1:2];
    logic [18:0]        r_x2   [3];
    logic [7:0]         r_col  [3:LAT][3];

    assign o_q_pop = !i_q_empty && (r_ocnt < OCW'(OUT_DEPTH));
    assign nz      = i_q_star.nz;
    assign tint[0] = i_q_star.tr;
    assign tint[1] = i_q_star.tg;
    assign tint[2] = i_q_star.tb;
    assign bright  = $signed(BRIGHT_TOP) - $signed({1'b0, 25'(nz) * 25'd175});
    assign mix     = MIX_DEN - 18'(21'(nz) * 21'd10);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ocnt <= '0;
            r_vld  <= '0;
        end else begin
            r_vld <= {r_vld[LAT-1:1], o_q_pop};
            case ({o_q_pop, i_out_pop})
                2'b10:   r_ocnt <= r_ocnt + 1'b1;
                2'b01:   r_ocnt <= r_ocnt - 1'b1;
                default: r_ocnt <= r_ocnt;
            endcase
        end
    end

    // stage 1: load from queue
    always_ff @(posedge i_clk) begin
        r_nz[1]   <= nz;
        r_rec[1]  <= i_q_star.recycle;
        r_size[1] <= (nz <= SIZE3_BOUND) ? 2'd3 : (nz <= SIZE2_BOUND) ? 2'd2 : 2'd1;
        r_den[1]  <= DEN_W'({nz, 2'b00}) + DEN_W'({nz, 1'b0});
        r_rx[1]   <= DEN_W'(i_q_numx >> QB);
        r_ry[1]   <= DEN_W'(i_q_numy >> QB);
        r_lx[1]   <= i_q_numx[QB-1:0];
        r_ly[1]   <= i_q_numy[QB-1:0];
        r_b1      <= bright[23:0];
        r_cb[1]   <= (nz <= COLOR_BOUND);
        r_grey[1] <= bright[25] ? 8'd0 : bright[23:16];
        for (int c = 0; c < 3; c++) begin
            r_f1[c] <= 26'(nz) * 26'd2550 + 26'(mix) * 26'(tint[c]);
        end
    end

    // stages 2 and 3: brightness times mix, then divide by 65536*255*D
    always_ff @(posedge i_clk) begin
        logic [49:0] p;
        logic [38:0] y;
        r_cb[2]   <= r_cb[1];
        r_grey[2] <= r_grey[1];
        for (int c = 0; c < 3; c++) begin
            p       = 50'(r_b1) * 50'(r_f1[c]);
            r_x2[c] <= p[49:31];
            y       = 39'(r_x2[c]) * 39'(RECIP1785);
            if (!r_cb[2]) begin
                r_col[3][c] <= r_grey[2];
            end else if (y[38:30] > 9'd255) begin
                r_col[3][c] <= 8'd255;
            end else begin
                r_col[3][c] <= y[37:30];
            end
        end
    end

    genvar k;
    generate
        for (k = 1; k < LAT; k++) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_nz[k+1]   <= r_nz[k];
                r_rec[k+1]  <= r_rec[k];
                r_size[k+1] <= r_size[k];
            end
        end
        for (k = 3; k < LAT; k++) begin : g_col
            always_ff @(posedge i_clk) begin
                r_col[k+1] <= r_col[k];
            end
        end
        // restoring division step: one quotient bit shifts in per stage
        for (k = 1; k <= QB; k++) begin : g_div
            logic [DEN_W:0] tx, ty;
            logic           gex, gey;
            assign tx  = {r_rx[k], r_lx[k][QB-1]};
            assign ty  = {r_ry[k], r_ly[k][QB-1]};
            assign gex = (tx >= {1'b0, r_den[k]});
            assign gey = (ty >= {1'b0, r_den[k]});
            always_ff @(posedge i_clk) begin
                r_lx[k+1] <= {r_lx[k][QB-2:0], gex};
                r_ly[k+1] <= {r_ly[k][QB-2:0], gey};
            end
            if (k < QB) begin : g_rem
                always_ff @(posedge i_clk) begin
                    r_den[k+1] <= r_den[k];
                    r_rx[k+1]  <= gex ? DEN_W'(tx - {1'b0, r_den[k]}) : tx[DEN_W-1:0];
                    r_ry[k+1]  <= gey ? DEN_W'(ty - {1'b0, r_den[k]}) : ty[DEN_W-1:0];
                end
            end
        end
    endgenerate

    assign o_out_push = r_vld[LAT];

    always_comb begin
        o_result           = '0;
        o_result.new_depth = r_nz[LAT];
        o_result.recycle   = r_rec[LAT];
        if (!r_rec[LAT]) begin
            o_result.screen_x = (int'(r_lx[LAT]) > 4095) ? 12'hFFF : 12'(r_lx[LAT]);
            o_result.screen_y = (int'(r_ly[LAT]) > 4095) ? 12'hFFF : 12'(r_ly[LAT]);
            o_result.dot_size = r_size[LAT];
            o_result.red      = r_col[LAT][0];
            o_result.green    = r_col[LAT][1];
            o_result.blue     = r_col[LAT][2];
        end
    end
endmodule

// ===== sv/starfield_star_project_shade.sv =====
// Top level: APB frame registers, front pipeline, middle queue, back pipeline, result queue.
// Depends on ssps_pkg, ssps_fifo, ssps_front, ssps_back.
//
//  channel   handshake         payload
//  input     push / full       i_dir_x i_dir_y i_depth i_speed i_tint_* i_elapsed_ms
//  result    empty / pop       o_new_depth o_recycle o_screen_* o_dot_size o_red/green/blue
//  config    psel penable ...  frame_width @0x0, frame_height @0x4 (13 bits)
//
// One star per cycle sustained while full stays low. The accepting edge loads the first
// of 5 front stages; a result then passes one write into each queue and log2(FRAME_MAX)+1
// back stages (one quotient bit per stage in the divide).
// Reset is synchronous and clears the queues, credits, valid bits and frame registers; no sweep.
// A held-off result queue fills, then the middle queue, then full rises.
module starfield_star_project_shade import ssps_pkg::*; #(
    parameter int FRAME_MAX = FRAME_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic [16:0]        i_depth,
    input  logic [11:0]        i_speed,
    input  logic [7:0]         i_tint_red,
    input  logic [7:0]         i_tint_green,
    input  logic [7:0]         i_tint_blue,
    input  logic [15:0]        i_elapsed_ms,
    output logic               empty,
    input  logic               pop,
    output logic [16:0]        o_new_depth,
    output logic               o_recycle,
    output logic [11:0]        o_screen_x,
    output logic [11:0]        o_screen_y,
    output logic [1:0]         o_dot_size,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int WB        = $clog2(FRAME_MAX + 1);
    localparam int NB        = WB + DEN_W;
    localparam int OUT_DEPTH = $clog2(FRAME_MAX) + 3;
    localparam int MID_W     = 2 * NB + $bits(t_star);

    logic [12:0]   r_frame_width, r_frame_height;
    logic [WB-1:0] frame_w, frame_h;
    logic          cfg_wr;

    logic             q_push, q_pop, q_empty;
    logic [NB-1:0]    q_numx, q_numy, h_numx, h_numy;
    t_star            q_star, h_star;
    logic [MID_W-1:0] h_data;
    logic             out_push;
    t_result          out_res, out_head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[12:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[12:0];
                default:          r_frame_width  <= r_frame_width;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FRAME_WIDTH:  prdata = 32'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = 32'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    // clamp to the largest supported frame
    assign frame_w = (int'(r_frame_width)  > FRAME_MAX) ? WB'(FRAME_MAX) : WB'(r_frame_width);
    assign frame_h = (int'(r_frame_height) > FRAME_MAX) ? WB'(FRAME_MAX) : WB'(r_frame_height);

    ssps_front #(.FRAME_MAX(FRAME_MAX)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_dir_x      (i_dir_x),
        .i_dir_y      (i_dir_y),
        .i_depth      (i_depth),
        .i_speed      (i_speed),
        .i_tint_red   (i_tint_red),
        .i_tint_green (i_tint_green),
        .i_tint_blue  (i_tint_blue),
        .i_elapsed_ms (i_elapsed_ms),
        .i_frame_w    (frame_w),
        .i_frame_h    (frame_h),
        .i_q_pop      (q_pop),
        .o_q_push     (q_push),
        .o_q_numx     (q_numx),
        .o_q_numy     (q_numy),
        .o_q_star     (q_star)
    );

    ssps_fifo #(.WIDTH(MID_W), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({q_numx, q_numy, q_star}),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (h_data)
    );

    assign {h_numx, h_numy, h_star} = h_data;

    ssps_back #(.FRAME_MAX(FRAME_MAX), .OUT_DEPTH(OUT_DEPTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_q_numx   (h_numx),
        .i_q_numy   (h_numy),
        .i_q_star   (h_star),
        .o_out_push (out_push),
        .i_out_pop  (pop && !empty),
        .o_result   (out_res)
    );

    ssps_fifo #(.WIDTH($bits(t_result)), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_res),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_head)
    );

    assign o_new_depth = out_head.new_depth;
    assign o_recycle   = out_head.recycle;
    assign o_screen_x  = out_head.screen_x;
    assign o_screen_y  = out_head.screen_y;
    assign o_dot_size  = out_head.dot_size;
    assign o_red       = out_head.red;
    assign o_green     = out_head.green;
    assign o_blue      = out_head.blue;
endmodule

// ===== tb/tb_starfield_star_project_shade.sv =====
// Testbench for starfield_star_project_shade: random and directed stars, frame register phases.
// Depends on ssps_pkg and the block's RTL; expected results come from an in-file shading model.
`timescale 1ns / 100ps

module tb_starfield_star_project_shade import ssps_pkg::*; ();

    localparam int CLK_PERIOD  = 12;
    localparam int DRAIN_WAIT  = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_STARS = 600;
    localparam int QUIET_STARS  = 100;
    localparam logic [2:0] ADDR_WIDTH  = {REG_FRAME_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_HEIGHT = {REG_FRAME_HEIGHT, 2'b00};

    typedef struct packed {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic [16:0]        z;
        logic [11:0]        spd;
        logic [7:0]         tr;
        logic [7:0]         tg;
        logic [7:0]         tb;
        logic [15:0]        dt;
    } t_star_item;

    localparam int STAR_BITS = $bits(t_star_item);

    class star_scoreboard;
        longint  frame_w;
        longint  frame_h;
        t_result pending_shades[$];
        int      mismatches;
        int      checked;

        function new();
            frame_w = 800;
            frame_h = 480;
            mismatches = 0;
            checked = 0;
        endfunction

        function void set_frame(bit is_height, logic [31:0] value);
            if (is_height) frame_h = value[12:0];
            else frame_w = value[12:0];
        endfunction

        function t_result shade_star(t_star_item s);
            t_result r;
            longint dx, dy, z, dec, nz, w, h, den, numx, numy, sn, sd, sz, b, m, cden, f, c;
            longint tint[3];
            longint chan[3];
            dx = s.dx;
            dy = s.dy;
            z = s.z;
            tint[0] = s.tr;
            tint[1] = s.tg;
            tint[2] = s.tb;
            dec = (longint'(s.spd) * longint'(s.dt)) / 33;
            nz = (z > dec) ? z - dec : 0;
            w = (frame_w > FRAME_MAX_DEF) ? FRAME_MAX_DEF : frame_w;
            h = (frame_h > FRAME_MAX_DEF) ? FRAME_MAX_DEF : frame_h;
            r = '0;
            r.new_depth = nz[16:0];
            if (nz <= NEAR_BOUND) begin
                r.recycle = 1'b1;
                return r;
            end
            den = 6 * nz;
            numx = 3 * w * nz + 4 * dx * w;
            numy = 3 * h * nz + 4 * dy * w;
            if (numx < 0 || numx >= w * den || numy < 0 || numy >= h * den) begin
                r.recycle = 1'b1;
                return r;
            end
            c = numx / den;
            r.screen_x = (c > 4095) ? 12'd4095 : c[11:0];
            c = numy / den;
            r.screen_y = (c > 4095) ? 12'd4095 : c[11:0];
            sz = 1;
            if (nz < 65536) begin
                sn = 200 * (65536 - nz);
                sd = 99 * 65536;
                sz = 1 + (2 * sn + sd) / (2 * sd);
                if (sz > 3) sz = 3;
            end
            r.dot_size = sz[1:0];
            b = 80 * 65536 + 175 * (65536 - nz);
            if (nz <= COLOR_BOUND) begin
                m = MIX_DEN - 10 * nz;
                cden = 65536 * 255 * longint'(MIX_DEN);
                for (int i = 0; i < 3; i++) begin
                    f = 255 * (MIX_DEN - m) + m * tint[i];
                    c = (b * f) / cden;
                    chan[i] = (c < 0) ? 0 : (c > 255) ? 255 : c;
                end
            end else begin
                c = (b < 0) ? 0 : b / 65536;
                if (c > 255) c = 255;
                for (int i = 0; i < 3; i++) chan[i] = c;
            end
            r.red = chan[0][7:0];
            r.green = chan[1][7:0];
            r.blue = chan[2][7:0];
            return r;
        endfunction

        function void note_star(t_star_item s);
            pending_shades = {pending_shades, shade_star(s)};
        endfunction

        function void check_result(t_result got);
            t_result want;
            checked++;
            if (pending_shades.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            want = pending_shades.pop_front();
            if (got.new_depth !== want.new_depth || got.recycle !== want.recycle ||
                got.screen_x !== want.screen_x || got.screen_y !== want.screen_y ||
                got.dot_size !== want.dot_size || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        empty;
    logic        pop = 1'b0;
    t_star_item  star = '0;
    t_result     shade_out;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    bit          quiet = 1'b0;
    int          cycles = 0;
    int          pop_stall = 0;
    int          stars_sent = 0;
    star_scoreboard sb = new();

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    starfield_star_project_shade DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_dir_x(star.dx), .i_dir_y(star.dy), .i_depth(star.z), .i_speed(star.spd),
        .i_tint_red(star.tr), .i_tint_green(star.tg), .i_tint_blue(star.tb),
        .i_elapsed_ms(star.dt), .empty(empty), .pop(pop),
        .o_new_depth(shade_out.new_depth), .o_recycle(shade_out.recycle),
        .o_screen_x(shade_out.screen_x), .o_screen_y(shade_out.screen_y),
        .o_dot_size(shade_out.dot_size), .o_red(shade_out.red), .o_green(shade_out.green),
        .o_blue(shade_out.blue), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Pop side: check each accepted result, stall in short random bursts.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        if (i_rst_n) begin
            if (pop && !empty) sb.check_result(shade_out);
            if (pop_stall > 0) begin
                pop_stall <= pop_stall - 1;
                pop <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                pop_stall <= $urandom_range(0, 3);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_star(t_star_item s);
        star <= s;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        sb.note_star(s);
        stars_sent++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every outstanding request has drained.
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (sb.pending_shades.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_frame(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_frame(addr[2], value);
    endtask

    function automatic t_star_item make_star(logic signed [15:0] dx, logic signed [15:0] dy,
                                             logic [16:0] z, logic [11:0] spd,
                                             logic [15:0] dt);
        t_star_item s;
        s.dx = dx;
        s.dy = dy;
        s.z = z;
        s.spd = spd;
        s.dt = dt;
        s.tr = 8'($urandom);
        s.tg = 8'($urandom);
        s.tb = 8'($urandom);
        return s;
    endfunction

    // Mostly on-screen stars with plausible motion, some raw noise.
    function automatic t_star_item random_star();
        t_star_item s;
        if ($urandom_range(0, 6) == 0) begin
            s = t_star_item'(STAR_BITS'({$urandom, $urandom, $urandom, $urandom}));
        end else begin
            s = make_star(16'($urandom_range(0, 12000) - 6000),
                          16'($urandom_range(0, 8000) - 4000),
                          17'($urandom_range(600, 65536)), 12'($urandom_range(0, 2048)),
                          16'($urandom_range(0, 60)));
            if ($urandom_range(0, 3) == 0) s.z = 17'($urandom_range(600, 24000));
        end
        return s;
    endfunction

    task automatic directed_stars();
        send_star(make_star(0, 0, 17'd65536, 0, 0));
        send_star(make_star(16'sh7FFF, 16'sh7FFF, 17'd65536, 0, 0));
        send_star(make_star(16'sh8000, 16'sh8000, 17'd65536, 0, 0));
        send_star(make_star(0, 0, 17'd655, 0, 0));          // at the near bound
        send_star(make_star(0, 0, 17'd656, 0, 0));
        send_star(make_star(0, 0, 17'd0, 0, 0));
        send_star(make_star(0, 0, 17'd1000, 12'd2048, 16'hFFFF));  // saturate to zero
        send_star(make_star(0, 0, 17'd22937, 0, 0));        // tint mix edge
        send_star(make_star(0, 0, 17'd22938, 0, 0));
        send_star(make_star(100, -100, 17'd16875, 0, 0));
        send_star(make_star(-50, 50, 17'd49315, 0, 0));
        send_star(make_star(10, 10, 17'h1FFFF, 12'hFFF, 16'd33));  // beyond 1.0
        send_star(make_star(0, 0, 17'd131071, 0, 0));
        send_star(make_star(16'sd20000, 0, 17'd2000, 0, 0));  // off the frame
        send_star(make_star(0, 16'sd20000, 17'd2000, 0, 0));
        send_star(make_star(0, 0, 17'd30000, 12'd2048, 16'd33));
        send_star(make_star(-200, 300, 17'd3000, 12'd100, 16'd16));
        send_star(make_star(0, 0, 17'd700, 0, 0));
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_stars();
        drain();
        write_frame(ADDR_WIDTH, 32'd1);
        write_frame(ADDR_HEIGHT, 32'd1);
        directed_stars();
        drain();
        write_frame(ADDR_WIDTH, 32'h1FFF);
        write_frame(ADDR_HEIGHT, 32'h1FFF);
        directed_stars();
        drain();
        write_frame(ADDR_WIDTH, 32'd0);
        directed_stars();
        drain();
        write_frame(ADDR_WIDTH, 32'd4096);
        write_frame(ADDR_HEIGHT, 32'd4096);
        for (int i = 0; i < RANDOM_STARS; i++) begin
            if (i % 150 == 149) begin
                drain();
                write_frame(ADDR_WIDTH, {$urandom} | 32'd1);
                write_frame(ADDR_HEIGHT, $urandom_range(1, 4096));
            end
            if (i == RANDOM_STARS - QUIET_STARS) begin
                drain();
                write_frame(ADDR_WIDTH, 32'd800);
                write_frame(ADDR_HEIGHT, 32'd480);
                quiet = 1'b1;
            end
            send_star(random_star());
        end
        drain();
        $display("%0d stars sent, %0d results checked across default, tiny, oversized,",
                 stars_sent, sb.checked);
        $display("zero-width and random frame settings, with stalls on both sides");
        if (sb.mismatches == 0 && sb.pending_shades.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ssps_pkg.sv
sv/ssps_fifo.sv
sv/ssps_front.sv
sv/ssps_back.sv
sv/starfield_star_project_shade.sv
tb/tb_starfield_star_project_shade.sv
